// ----- hw/rtl/tbpiq_pkg.sv -----
package tbpiq_pkg;

   localparam int unsigned LOCKOUT_WIDTH  = 8;
   localparam int unsigned VALUE_WIDTH    = 8;
   localparam int unsigned CSR_DATA_WIDTH = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 2;

   // register reset values
   localparam logic [LOCKOUT_WIDTH-1:0] LOCKOUT_RESET = 8'd100;
   localparam logic [31:0] UNLOCK_HOLD_RESET     = 32'd2000;
   localparam logic [31:0] UNLOCK_WINDOW_RESET   = 32'd200;
   localparam logic [31:0] DISPLAY_TIMEOUT_RESET = 32'd3000;

   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_TICK   = 2'd1,
      OP_READ   = 2'd2
   } opcode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_LOCKOUT_TICKS   = 2'd0,
      REG_UNLOCK_HOLD     = 2'd1,
      REG_UNLOCK_WINDOW   = 2'd2,
      REG_DISPLAY_TIMEOUT = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic                   show_address;
      logic                   step_down;
      logic                   step_up;
      logic                   show_count;
      logic [VALUE_WIDTH-1:0] count_value;
      logic                   unlock_event;
      logic                   lock_event;
      logic [VALUE_WIDTH-1:0] read_value;
   } rsp_type;

endpackage

// ----- hw/rtl/two_button_pulse_input_qualifier_unit.sv -----
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | req_opcode, req_up_level, req_down_level,
//         |           |                       | req_pulse_level
// rsp     | out       | rsp_valid / rsp_ready | rsp_show_address ... rsp_read_value
// csr     | in        | csr_valid / csr_ready | csr_index, csr_data
//
// every beat passes from req to rsp through the input register and then the result
// register; one beat per cycle unless rsp stalls, set by the single update pass
// sync active-high reset clears state, counters, timers and both stage valids;
// registers go to their power-on values, csr_ready is always high
// a stalled rsp holds the result register; the input register keeps accepting while
// the result register is free or drains in the same cycle
module two_button_pulse_input_qualifier_unit
   import tbpiq_pkg::*;
#(
   parameter int unsigned PULSE_COUNT_WIDTH = 8,
   parameter int unsigned TIMER_WIDTH       = 16
) (
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_opcode,
   input  logic                       req_up_level,
   input  logic                       req_down_level,
   input  logic                       req_pulse_level,

   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_show_address,
   output logic                       rsp_step_down,
   output logic                       rsp_step_up,
   output logic                       rsp_show_count,
   output logic [VALUE_WIDTH-1:0]     rsp_count_value,
   output logic                       rsp_unlock_event,
   output logic                       rsp_lock_event,
   output logic [VALUE_WIDTH-1:0]     rsp_read_value,

   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   // configuration registers
   logic [LOCKOUT_WIDTH-1:0] lockout_ticks_ff;
   logic [TIMER_WIDTH-1:0]   unlock_hold_ff;
   logic [TIMER_WIDTH-1:0]   unlock_window_ff;
   logic [TIMER_WIDTH-1:0]   display_timeout_ff;
   logic [31:0]              csr_wide;

   // input stage
   logic       s1_valid_ff;
   logic [1:0] s1_opcode_ff;
   logic       s1_up_ff;
   logic       s1_down_ff;
   logic       s1_pulse_ff;
   logic       s1_advance;

   // qualifier state
   logic                         down_state_ff,    down_state_in;
   logic                         up_state_ff,      up_state_in;
   logic                         pulse_state_ff,   pulse_state_in;
   logic                         ignore_ff,        ignore_in;
   logic [LOCKOUT_WIDTH-1:0]     down_lockout_ff,  down_lockout_in;
   logic [LOCKOUT_WIDTH-1:0]     up_lockout_ff,    up_lockout_in;
   logic [LOCKOUT_WIDTH-1:0]     pulse_lockout_ff, pulse_lockout_in;
   logic [TIMER_WIDTH-1:0]       display_timer_ff, display_timer_in;
   logic [TIMER_WIDTH-1:0]       unlock_timer_ff,  unlock_timer_in;
   logic [PULSE_COUNT_WIDTH-1:0] pulse_count_ff,   pulse_count_in;

   // result stage
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   assign csr_ready  = 1'b1;
   assign csr_wide   = 32'(csr_data);

   // result register frees when empty or draining this cycle
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;

   // config writes must arrive only while idle; the user is bound, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ticks_ff   <= LOCKOUT_RESET;
         unlock_hold_ff     <= UNLOCK_HOLD_RESET[TIMER_WIDTH-1:0];
         unlock_window_ff   <= UNLOCK_WINDOW_RESET[TIMER_WIDTH-1:0];
         display_timeout_ff <= DISPLAY_TIMEOUT_RESET[TIMER_WIDTH-1:0];
      end else if (csr_valid && csr_ready) begin
         case (reg_index_type'(csr_index))
            REG_LOCKOUT_TICKS:   lockout_ticks_ff   <= csr_data[LOCKOUT_WIDTH-1:0];
            REG_UNLOCK_HOLD:     unlock_hold_ff     <= csr_wide[TIMER_WIDTH-1:0];
            REG_UNLOCK_WINDOW:   unlock_window_ff   <= csr_wide[TIMER_WIDTH-1:0];
            REG_DISPLAY_TIMEOUT: display_timeout_ff <= csr_wide[TIMER_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_opcode_ff <= req_opcode;
         s1_up_ff     <= req_up_level;
         s1_down_ff   <= req_down_level;
         s1_pulse_ff  <= req_pulse_level;
      end
   end

   // one update pass; a sample: decrement button, then increment button, then
   // pulse line, unlock hold, display timeout; a tick decrements, a read clears
   always_comb begin
      logic [31:0] count_old_wide;
      logic [31:0] count_new_wide;

      down_state_in    = down_state_ff;
      up_state_in      = up_state_ff;
      pulse_state_in   = pulse_state_ff;
      ignore_in        = ignore_ff;
      down_lockout_in  = down_lockout_ff;
      up_lockout_in    = up_lockout_ff;
      pulse_lockout_in = pulse_lockout_ff;
      display_timer_in = display_timer_ff;
      unlock_timer_in  = unlock_timer_ff;
      pulse_count_in   = pulse_count_ff;
      rsp_in           = '0;
      count_old_wide   = 32'(pulse_count_ff);

      case (opcode_type'(s1_opcode_ff))
         OP_SAMPLE: begin
            // decrement button
            if (!down_state_in && s1_down_ff && down_lockout_in == '0) begin
               down_lockout_in     = lockout_ticks_ff;
               down_state_in       = 1'b1;
               rsp_in.show_address = 1'b1;
            end else if (down_state_in && !s1_down_ff && down_lockout_in == '0) begin
               down_lockout_in = lockout_ticks_ff;
               down_state_in   = 1'b0;
               unlock_timer_in = '0;
               if (!up_state_in) begin
                  rsp_in.step_down = !ignore_in;
                  ignore_in        = 1'b0;
               end else begin
                  ignore_in = 1'b1;
               end
            end
            // increment button sees the updated decrement state
            if (!up_state_in && s1_up_ff && up_lockout_in == '0) begin
               up_lockout_in       = lockout_ticks_ff;
               up_state_in         = 1'b1;
               rsp_in.show_address = 1'b1;
            end else if (up_state_in && !s1_up_ff && up_lockout_in == '0) begin
               up_lockout_in   = lockout_ticks_ff;
               up_state_in     = 1'b0;
               unlock_timer_in = '0;
               if (!down_state_in) begin
                  rsp_in.step_up = !ignore_in;
                  ignore_in      = 1'b0;
               end else begin
                  ignore_in = 1'b1;
               end
            end
            // pulse line counts on the falling edge
            if (!pulse_state_in && s1_pulse_ff && pulse_lockout_in == '0) begin
               pulse_lockout_in = lockout_ticks_ff;
               pulse_state_in   = 1'b1;
            end else if (pulse_state_in && !s1_pulse_ff && pulse_lockout_in == '0) begin
               pulse_lockout_in    = lockout_ticks_ff;
               pulse_state_in      = 1'b0;
               pulse_count_in      = pulse_count_in + PULSE_COUNT_WIDTH'(1);
               rsp_in.show_address = 1'b1;
               rsp_in.show_count   = 1'b1;
            end
            // both held with both lockouts expired: arm, then fire inside the window
            if (s1_up_ff && s1_down_ff && down_lockout_in == '0 && up_lockout_in == '0)
            begin
               if (unlock_timer_in == '0) begin
                  unlock_timer_in = unlock_hold_ff;
               end
               rsp_in.unlock_event = (unlock_timer_in <= unlock_window_ff);
            end
            // any held button keeps the display awake
            if (s1_up_ff || s1_down_ff) begin
               display_timer_in = display_timeout_ff;
            end
            rsp_in.lock_event = (display_timer_in == '0);
         end
         OP_TICK: begin
            if (down_lockout_ff != '0)  down_lockout_in  = down_lockout_ff - 1'b1;
            if (up_lockout_ff != '0)    up_lockout_in    = up_lockout_ff - 1'b1;
            if (pulse_lockout_ff != '0) pulse_lockout_in = pulse_lockout_ff - 1'b1;
            if (display_timer_ff != '0) display_timer_in = display_timer_ff - 1'b1;
            if (unlock_timer_ff != '0)  unlock_timer_in  = unlock_timer_ff - 1'b1;
         end
         OP_READ: begin
            rsp_in.read_value = count_old_wide[VALUE_WIDTH-1:0];
            pulse_count_in    = '0;
         end
         default: ;
      endcase

      count_new_wide     = 32'(pulse_count_in);
      rsp_in.count_value = count_new_wide[VALUE_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         down_state_ff    <= 1'b0;
         up_state_ff      <= 1'b0;
         pulse_state_ff   <= 1'b0;
         ignore_ff        <= 1'b0;
         down_lockout_ff  <= '0;
         up_lockout_ff    <= '0;
         pulse_lockout_ff <= '0;
         display_timer_ff <= '0;
         unlock_timer_ff  <= '0;
         pulse_count_ff   <= '0;
      end else if (s1_advance) begin
         down_state_ff    <= down_state_in;
         up_state_ff      <= up_state_in;
         pulse_state_ff   <= pulse_state_in;
         ignore_ff        <= ignore_in;
         down_lockout_ff  <= down_lockout_in;
         up_lockout_ff    <= up_lockout_in;
         pulse_lockout_ff <= pulse_lockout_in;
         display_timer_ff <= display_timer_in;
         unlock_timer_ff  <= unlock_timer_in;
         pulse_count_ff   <= pulse_count_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_show_address = rsp_ff.show_address;
   assign rsp_step_down    = rsp_ff.step_down;
   assign rsp_step_up      = rsp_ff.step_up;
   assign rsp_show_count   = rsp_ff.show_count;
   assign rsp_count_value  = rsp_ff.count_value;
   assign rsp_unlock_event = rsp_ff.unlock_event;
   assign rsp_lock_event   = rsp_ff.lock_event;
   assign rsp_read_value   = rsp_ff.read_value;

   // a beat leaving the input stage lands in the result register
   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_valid_ff)
      else $error("advanced beat missing from result register");

   // the result register never drops an untaken beat
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("stalled result lost or changed");

   // one release can only step one way
   a_step_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.step_up && rsp_ff.step_down))
      else $error("step up and step down in one beat");

   // a counted pulse always wakes the display
   a_count_wakes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.show_count |-> rsp_ff.show_address)
      else $error("pulse counted without wake");

   // a read leaves the count cleared
   a_read_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.read_value != '0 |-> rsp_ff.count_value == '0)
      else $error("count not cleared by read");

endmodule
